/* hw/rtl/universal_char_escape_to_utf8_core_macros.svh */
// Assertion macros for the escape-to-UTF-8 core.
// Define NO_ASSERTIONS to compile them away.
`ifndef UNIVERSAL_CHAR_ESCAPE_TO_UTF8_CORE_MACROS_SVH
`define UNIVERSAL_CHAR_ESCAPE_TO_UTF8_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk_i, off during reset.
`define UCU8_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, clocked on clk_i, off during reset.
`define UCU8_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define UCU8_ASSERT_IMP(lbl, ante, cons)
`define UCU8_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ucu8_pkg.sv */
`default_nettype none
package ucu8_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_SLASH  = 2'd1,
    MODE_DIGITS = 2'd2
  } scan_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DUMP = 2'd1,
    PH_BYTE = 2'd2,
    PH_ENC  = 2'd3
  } phase_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;

  localparam logic [3:0] SHORT_DIGITS = 4'd4;
  localparam logic [3:0] LONG_DIGITS  = 4'd8;

  // Control handed from the sequencer to the byte generator.
  typedef struct packed {
    phase_e      phase;
    logic [3:0]  idx;
    logic        long_form;
    logic [7:0]  text_byte;
    logic [2:0]  enc_nb;
    logic [31:0] enc_code;
    logic [7:0]  held_byte;
  } gen_ctrl_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // Number of UTF-8 bytes for a code value.
  function automatic logic [2:0] enc_len(input logic [31:0] c);
    if (c <= 32'h7F) return 3'd1;
    else if (c <= 32'h7FF) return 3'd2;
    else if (c <= 32'hFFFF) return 3'd3;
    return 3'd4;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ucu8_byte_gen.sv */
`default_nettype none
module ucu8_byte_gen (
  input  ucu8_pkg::gen_ctrl_t ctrl_i,
  output logic [7:0]          byte_o
);
  import ucu8_pkg::*;

  logic [2:0] cont_sel;
  logic [7:0] lead_byte;
  logic [7:0] cont_byte;

  // Continuation byte k carries bits [6*(nb-1-k) +: 6].
  assign cont_sel = ctrl_i.enc_nb - 3'd1 - ctrl_i.idx[2:0];

  always_comb begin
    case (ctrl_i.enc_nb)
      3'd1:    lead_byte = ctrl_i.enc_code[7:0];
      3'd2:    lead_byte = 8'hC0 | ctrl_i.enc_code[13:6];
      3'd3:    lead_byte = 8'hE0 | ctrl_i.enc_code[19:12];
      default: lead_byte = 8'hF0 | ctrl_i.enc_code[25:18];
    endcase
    case (cont_sel)
      3'd0:    cont_byte = {2'b10, ctrl_i.enc_code[5:0]};
      3'd1:    cont_byte = {2'b10, ctrl_i.enc_code[11:6]};
      default: cont_byte = {2'b10, ctrl_i.enc_code[17:12]};
    endcase
  end

  always_comb begin
    case (ctrl_i.phase)
      PH_DUMP: begin
        case (ctrl_i.idx)
          4'd0:    byte_o = CH_BSLASH;
          4'd1:    byte_o = ctrl_i.long_form ? CH_UP_U : CH_LOW_U;
          default: byte_o = ctrl_i.held_byte;
        endcase
      end
      PH_BYTE: byte_o = ctrl_i.text_byte;
      PH_ENC:  byte_o = (ctrl_i.idx == 4'd0) ? lead_byte : cont_byte;
      default: byte_o = 8'h00;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/universal_char_escape_to_utf8_core.sv */
// Escape rewriter: takes source text one byte per beat and replaces \uXXXX and
// \UXXXXXXXX escapes by their UTF-8 encoding (1 to 4 bytes; above 0x1FFFFF the
// leading byte keeps only its low 8 bits). Escapes with a non-hex digit or a
// zero value, and a backslash before any other byte, pass through unchanged.
// s_axis_tlast_i marks the final byte of a text and flushes any pending escape
// bytes. On the output, m_axis_tlast_o marks the last byte caused by one input
// beat and m_axis_tuser_o the very last byte of the text. An input beat is
// accepted while the byte sequencer is idle; the sequencer then emits the
// beat's bytes one per cycle while the output is not stalled. A beat that
// yields no bytes, such as a held escape digit, leaves the sequencer idle. The
// input is not ready while the sequencer emits; the output register lets the
// next beat be taken while the last byte still waits downstream.
`default_nettype none
module universal_char_escape_to_utf8_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // run_last
  output logic       m_axis_tuser_o    // [0] text_done
);
  import ucu8_pkg::*;
  `include "universal_char_escape_to_utf8_core_macros.svh"

  // Scanner state
  scan_mode_e  mode_q, mode_d;
  logic        long_q, long_d;
  logic [3:0]  digits_q, digits_d;
  logic [31:0] code_q, code_d;
  logic [7:0]  held_q [8];

  // Per-beat plan, captured at accept
  logic [3:0]  dump_len_q;
  logic        emit_b_q;
  logic [2:0]  enc_nb_q;
  logic [31:0] enc_code_q;
  logic [7:0]  byte_q;
  logic        plan_long_q;
  logic        end_q;

  // Sequencer
  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_done_q;

  logic        s_acc;
  logic        produce;
  logic        is_last;
  logic [4:0]  hx;
  logic [3:0]  need;
  logic [3:0]  dn;
  logic [31:0] code_n;
  logic        held_we;
  logic [3:0]  p_dump;
  logic        p_emit;
  logic [2:0]  p_enc_nb;
  logic        p_long;
  logic        b_is_bs;
  logic [3:0]  hidx;
  gen_ctrl_t   gen_ctrl;
  logic [7:0]  gen_byte;

  assign s_axis_tready_o = (phase_q == PH_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign produce         = (phase_q != PH_IDLE) && (!out_valid_q || m_axis_tready_i);

  // Work out what this beat emits and where the scanner goes.
  always_comb begin
    hx       = hex_decode(s_axis_tdata_i);
    need     = long_q ? LONG_DIGITS : SHORT_DIGITS;
    dn       = digits_q + 4'd1;
    code_n   = {code_q[27:0], hx[3:0]};
    b_is_bs  = (s_axis_tdata_i == CH_BSLASH);
    mode_d   = mode_q;
    long_d   = long_q;
    digits_d = digits_q;
    code_d   = code_q;
    p_dump   = 4'd0;
    p_emit   = 1'b0;
    p_enc_nb = 3'd0;
    p_long   = long_q;
    held_we  = 1'b0;
    case (mode_q)
      MODE_SLASH: begin
        if (s_axis_tdata_i == CH_LOW_U || s_axis_tdata_i == CH_UP_U) begin
          mode_d   = MODE_DIGITS;
          long_d   = (s_axis_tdata_i == CH_UP_U);
          p_long   = (s_axis_tdata_i == CH_UP_U);
          digits_d = 4'd0;
          code_d   = 32'd0;
          if (s_axis_tlast_i) p_dump = 4'd2;
        end else begin
          // Not an escape: backslash and byte go out as they are.
          p_dump = 4'd1;
          p_emit = 1'b1;
          mode_d = MODE_PLAIN;
        end
      end
      MODE_DIGITS: begin
        if (!hx[4] || digits_q >= need) begin
          // Broken escape: flush it, then treat the byte as plain text.
          p_dump   = 4'd2 + digits_q;
          long_d   = 1'b0;
          digits_d = 4'd0;
          code_d   = 32'd0;
          if (b_is_bs && !s_axis_tlast_i) begin
            mode_d = MODE_SLASH;
          end else begin
            mode_d = MODE_PLAIN;
            p_emit = 1'b1;
          end
        end else begin
          held_we = 1'b1;
          if (dn == need) begin
            if (code_n != 32'd0) p_enc_nb = enc_len(code_n);
            else                 p_dump   = 4'd2 + dn;
            mode_d   = MODE_PLAIN;
            long_d   = 1'b0;
            digits_d = 4'd0;
            code_d   = 32'd0;
          end else begin
            digits_d = dn;
            code_d   = code_n;
            if (s_axis_tlast_i) p_dump = 4'd2 + dn;
          end
        end
      end
      default: begin
        if (b_is_bs && !s_axis_tlast_i) begin
          mode_d = MODE_SLASH;
        end else begin
          mode_d = MODE_PLAIN;
          p_emit = 1'b1;
        end
      end
    endcase
    // End of text: drop back to plain mode for the next text.
    if (s_axis_tlast_i) begin
      mode_d   = MODE_PLAIN;
      long_d   = 1'b0;
      digits_d = 4'd0;
      code_d   = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_PLAIN;
      long_q     <= 1'b0;
      digits_q   <= 4'd0;
      code_q     <= 32'd0;
      dump_len_q <= 4'd0;
      emit_b_q   <= 1'b0;
      enc_nb_q   <= 3'd0;
      end_q      <= 1'b0;
    end else if (s_acc) begin
      mode_q     <= mode_d;
      long_q     <= long_d;
      digits_q   <= digits_d;
      code_q     <= code_d;
      dump_len_q <= p_dump;
      emit_b_q   <= p_emit;
      enc_nb_q   <= p_enc_nb;
      end_q      <= s_axis_tlast_i;
    end
  end

  // Payload of the plan and the held digit bytes: no reset.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      enc_code_q  <= code_n;
      byte_q      <= s_axis_tdata_i;
      plan_long_q <= p_long;
      if (held_we) held_q[digits_q[2:0]] <= s_axis_tdata_i;
    end
  end

  // Byte sequencer: dump pending escape bytes, then the beat's own byte,
  // then the UTF-8 bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    is_last = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (s_acc) begin
          idx_d = 4'd0;
          if (p_dump != 4'd0)        phase_d = PH_DUMP;
          else if (p_emit)           phase_d = PH_BYTE;
          else if (p_enc_nb != 3'd0) phase_d = PH_ENC;
          else                       phase_d = PH_IDLE;
        end
      end
      PH_DUMP: begin
        is_last = (idx_q == dump_len_q - 4'd1) && !emit_b_q && (enc_nb_q == 3'd0);
        if (produce) begin
          if (idx_q == dump_len_q - 4'd1) begin
            idx_d = 4'd0;
            if (emit_b_q)              phase_d = PH_BYTE;
            else if (enc_nb_q != 3'd0) phase_d = PH_ENC;
            else                       phase_d = PH_IDLE;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      PH_BYTE: begin
        is_last = (enc_nb_q == 3'd0);
        if (produce) begin
          idx_d   = 4'd0;
          phase_d = (enc_nb_q != 3'd0) ? PH_ENC : PH_IDLE;
        end
      end
      PH_ENC: begin
        is_last = (idx_q[2:0] == enc_nb_q - 3'd1);
        if (produce) begin
          if (idx_q[2:0] == enc_nb_q - 3'd1) begin
            idx_d   = 4'd0;
            phase_d = PH_IDLE;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        idx_d   = 4'd0;
      end
    endcase
  end

  // Held digit k sits at dump position k + 2.
  assign hidx = idx_q - 4'd2;

  assign gen_ctrl = '{
    phase:     phase_q,
    idx:       idx_q,
    long_form: plan_long_q,
    text_byte: byte_q,
    enc_nb:    enc_nb_q,
    enc_code:  enc_code_q,
    held_byte: held_q[hidx[2:0]]
  };

  ucu8_byte_gen u_byte_gen (
    .ctrl_i (gen_ctrl),
    .byte_o (gen_byte)
  );

  // Output register: load on produce, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_byte_q <= gen_byte;
      out_last_q <= is_last;
      out_done_q <= is_last && end_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

  `UCU8_ASSERT_IMP(a_done_is_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)
  `UCU8_ASSERT_NXT(a_end_to_plain, s_acc && s_axis_tlast_i, mode_q == MODE_PLAIN && digits_q == 4'd0)
  `UCU8_ASSERT_IMP(a_digit_bound, mode_q == MODE_DIGITS, digits_q < (long_q ? LONG_DIGITS : SHORT_DIGITS))
  `UCU8_ASSERT_IMP(a_dump_index, phase_q == PH_DUMP, idx_q < dump_len_q)

endmodule
`default_nettype wire

/* verif/universal_char_escape_to_utf8_core_tb.sv */
`default_nettype none
module universal_char_escape_to_utf8_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucu8_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_PCT     = 21;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 24;
  localparam int MAX_PRINTS   = 50;

  // UTF-8 lead and continuation prefixes
  localparam logic [31:0] UTF8_LEAD2 = 32'd192;
  localparam logic [31:0] UTF8_LEAD3 = 32'd224;
  localparam logic [31:0] UTF8_LEAD4 = 32'd240;
  localparam logic [7:0]  UTF8_CONT  = 8'd128;

  typedef struct {
    logic [7:0] text_byte;
    logic       eot;
    bit         typed;        // expected bytes spelled out below
    string      typed_bytes;
  } text_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       text_done;
  } utf8_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] text_byte
  logic       s_axis_tlast_i = 1'b0;    // end_of_text
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic       m_axis_tlast_o;           // run_last
  logic       m_axis_tuser_o;           // [0] text_done

  universal_char_escape_to_utf8_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Escape scanner copy kept in step with every accepted input beat.
  scan_mode_e  esc_mode = MODE_PLAIN;
  logic        esc_long = 1'b0;
  logic [3:0]  esc_ndig = 4'd0;
  logic [31:0] esc_code = 32'd0;
  logic [7:0]  esc_digits [8];
  logic [7:0]  rewritten_q [$];   // bytes produced by the current input beat

  text_beat_t  text_plan_q [$];
  text_beat_t  smoke_tbl [27];
  utf8_byte_t  utf8_due_q [$];    // expected output bytes, oldest first

  int  accepted_n  = 0;
  int  stall_n     = 0;
  int  mismatch_n  = 0;
  bit  calm        = 1'b0;        // both sides hold off idling while set

  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // Pass any half-read escape through as raw bytes and return to plain text.
  task automatic flush_escape();
    if (esc_mode == MODE_SLASH) begin
      rewritten_q.push_back(CH_BSLASH);
    end else if (esc_mode == MODE_DIGITS) begin
      rewritten_q.push_back(CH_BSLASH);
      rewritten_q.push_back(esc_long ? CH_UP_U : CH_LOW_U);
      for (int i = 0; i < int'(esc_ndig) && i < 8; i++) rewritten_q.push_back(esc_digits[i]);
    end
    esc_mode = MODE_PLAIN;
    esc_long = 1'b0;
    esc_ndig = 4'd0;
    esc_code = 32'd0;
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (b == CH_BSLASH) esc_mode = MODE_SLASH;
    else rewritten_q.push_back(b);
  endtask

  task automatic rewrite_byte(input logic [7:0] b, input logic eot);
    int          h;
    logic [3:0]  need;
    logic [31:0] lead;
    rewritten_q.delete();
    case (esc_mode)
      MODE_SLASH: begin
        if (b == CH_LOW_U || b == CH_UP_U) begin
          esc_long = (b == CH_UP_U);
          esc_ndig = 4'd0;
          esc_code = 32'd0;
          esc_mode = MODE_DIGITS;
        end else begin
          rewritten_q.push_back(CH_BSLASH);
          rewritten_q.push_back(b);
          esc_mode = MODE_PLAIN;
        end
      end
      MODE_DIGITS: begin
        h    = hex_value(b);
        need = esc_long ? LONG_DIGITS : SHORT_DIGITS;
        if (h < 0 || esc_ndig >= need) begin
          flush_escape();
          take_plain(b);
        end else begin
          esc_digits[esc_ndig[2:0]] = b;
          esc_code = {esc_code[27:0], 4'(h)};
          esc_ndig = esc_ndig + 4'd1;
          if (esc_ndig == need) begin
            if (esc_code == 32'd0) begin
              flush_escape();
            end else begin
              if (esc_code <= 32'h7F) begin
                rewritten_q.push_back(esc_code[7:0]);
              end else if (esc_code <= 32'h7FF) begin
                lead = UTF8_LEAD2 | (esc_code >> 6);
                rewritten_q.push_back(lead[7:0]);
                rewritten_q.push_back(UTF8_CONT | esc_code[5:0]);
              end else if (esc_code <= 32'hFFFF) begin
                lead = UTF8_LEAD3 | (esc_code >> 12);
                rewritten_q.push_back(lead[7:0]);
                rewritten_q.push_back(UTF8_CONT | esc_code[11:6]);
                rewritten_q.push_back(UTF8_CONT | esc_code[5:0]);
              end else begin
                // lead byte keeps only its low 8 bits above 0x1FFFFF
                lead = UTF8_LEAD4 | (esc_code >> 18);
                rewritten_q.push_back(lead[7:0]);
                rewritten_q.push_back(UTF8_CONT | esc_code[17:12]);
                rewritten_q.push_back(UTF8_CONT | esc_code[11:6]);
                rewritten_q.push_back(UTF8_CONT | esc_code[5:0]);
              end
              esc_mode = MODE_PLAIN;
              flush_escape();
            end
          end
        end
      end
      default: begin
        esc_mode = MODE_PLAIN;
        take_plain(b);
      end
    endcase
    if (eot) flush_escape();
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_n < MAX_PRINTS) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_n++;
  endtask

  // Build the random text: mostly escapes with random digits, some broken
  // escapes, zero escapes, backslash pairs and plain runs; end of text now
  // and then, also inside an escape.
  task automatic plan_random_text();
    logic [7:0] tok [$];
    logic [7:0] b;
    int         kind;
    int         ndig;
    int         brk;
    int         nib;
    bit         long_esc;
    bit         zero;
    int         n_rand;
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      tok.delete();
      kind = $urandom_range(99);
      if (kind < 25) begin
        repeat ($urandom_range(4, 1)) tok.push_back(8'($urandom_range(255)));
      end else if (kind < 88) begin
        long_esc = 1'($urandom_range(1));
        ndig     = long_esc ? 8 : 4;
        zero     = (kind >= 80);
        brk      = (kind >= 70 && kind < 80) ? $urandom_range(ndig - 1) : -1;
        tok.push_back(CH_BSLASH);
        tok.push_back(long_esc ? CH_UP_U : CH_LOW_U);
        for (int i = 0; i < ndig; i++) begin
          if (i == brk) begin
            if ($urandom_range(2) == 0) begin
              b = CH_BSLASH;
            end else begin
              do b = 8'($urandom_range(255)); while (hex_value(b) >= 0);
            end
            tok.push_back(b);
            break;
          end
          nib = $urandom_range(15);
          if (zero || $urandom_range(9) < 4) b = "0";
          else if (nib < 10) b = 8'(int'("0") + nib);
          else if ($urandom_range(1) == 1) b = 8'(int'("A") + nib - 10);
          else b = 8'(int'("a") + nib - 10);
          tok.push_back(b);
        end
      end else begin
        tok.push_back(CH_BSLASH);
        tok.push_back(8'($urandom_range(255)));
      end
      foreach (tok[i]) begin
        text_plan_q.push_back('{tok[i], 1'($urandom_range(99) < 3), 1'b0, ""});
        n_rand++;
      end
    end
    text_plan_q[text_plan_q.size() - 1].eot = 1'b1;
  endtask

  // Check output beats, predict on input beats, count quiet cycles.
  always @(posedge clk_i) begin
    utf8_byte_t want;
    text_beat_t row;
    int         n;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (utf8_due_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with nothing expected", m_axis_tdata_o));
        end else begin
          want = utf8_due_q.pop_front();
          if (m_axis_tdata_o !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", m_axis_tdata_o, want.data));
          if (m_axis_tlast_o !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                      m_axis_tlast_o, want.run_last, want.data));
          if (m_axis_tuser_o !== want.text_done)
            report_mismatch($sformatf("text_done %b, expected %b on byte %02h",
                                      m_axis_tuser_o, want.text_done, want.data));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        row = text_plan_q[accepted_n];
        accepted_n++;
        rewrite_byte(s_axis_tdata_i, s_axis_tlast_i);
        if (row.typed) begin
          rewritten_q.delete();
          for (int i = 0; i < row.typed_bytes.len(); i++) rewritten_q.push_back(row.typed_bytes[i]);
        end
        n = rewritten_q.size();
        for (int i = 0; i < n; i++)
          utf8_due_q.push_back('{rewritten_q[i], i == n - 1, (i == n - 1) && s_axis_tlast_i});
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        stall_n = 0;
      else
        stall_n++;
    end
  end

  // Receiver: drop tready about one cycle in five, never while calm.
  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    wait (stall_n >= STALL_LIMIT);
    $display("[universal_char_escape_to_utf8_core] ERROR");
    $finish;
  end

  initial begin
    int pause_at;
    int calm_lo;
    smoke_tbl = '{
      '{8'h41,     1'b0, 1'b1, "A"},
      '{8'h00,     1'b0, 1'b0, ""},            // zero byte is plain text
      '{CH_BSLASH, 1'b0, 1'b1, ""},
      '{"n",       1'b0, 1'b1, "\\n"},         // backslash before another byte
      '{CH_BSLASH, 1'b0, 1'b1, ""},
      '{CH_LOW_U,  1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, ""},
      '{CH_BSLASH, 1'b0, 1'b1, "\\u000"},      // non-hex breaks, opens a new escape
      '{CH_UP_U,   1'b0, 1'b1, ""},
      '{"F",       1'b0, 1'b1, ""},
      '{"F",       1'b0, 1'b1, ""},
      '{"F",       1'b0, 1'b1, ""},
      '{"F",       1'b0, 1'b1, ""},
      '{"f",       1'b0, 1'b1, ""},
      '{"f",       1'b0, 1'b1, ""},
      '{"f",       1'b0, 1'b1, ""},
      '{"f",       1'b0, 1'b1, "\377\277\277\277"},  // lead byte cut to 8 bits
      '{CH_BSLASH, 1'b0, 1'b1, ""},
      '{CH_LOW_U,  1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, ""},
      '{"0",       1'b0, 1'b1, "\\u0000"},     // zero value passes through
      '{CH_BSLASH, 1'b1, 1'b1, "\\"},          // end of text flushes backslash
      '{8'hFF,     1'b1, 1'b1, "\377"}
    };
    foreach (smoke_tbl[i]) text_plan_q.push_back(smoke_tbl[i]);
    plan_random_text();

    pause_at = $size(smoke_tbl) + $urandom_range(150, 50);
    calm_lo  = $size(smoke_tbl) + $urandom_range(300, 200);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (text_plan_q[i]) begin
      calm = (i >= calm_lo) && (i < calm_lo + 120);
      // hold off until the block has drained everything owed so far
      if (i == $size(smoke_tbl) || i == pause_at) begin
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (utf8_due_q.size() != 0);
      end
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= text_plan_q[i].text_byte;
      s_axis_tlast_i  <= text_plan_q[i].eot;
      do @(posedge clk_i); while (!s_axis_tready_o);
    end
    s_axis_tvalid_i <= 1'b0;
    calm = 1'b0;

    while (utf8_due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_n == 0) begin
      $display("[universal_char_escape_to_utf8_core] OK");
    end else begin
      $display("[universal_char_escape_to_utf8_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/ucu8_pkg.sv
hw/rtl/ucu8_byte_gen.sv
hw/rtl/universal_char_escape_to_utf8_core.sv
verif/universal_char_escape_to_utf8_core_tb.sv
